// ===== hw/rtl/dwg_pkg.sv =====
// Shared types, constants and scaling functions for the diagonal weighted glow filter.
// No dependencies; every file of the block but dwg_ram imports this package.
package dwg_pkg;

	// Defaults and fixed field widths
	localparam int DEF_MAX_SIDE = 1024;
	localparam int SIZE_W       = 11;
	localparam int CHAN_W       = 16;
	localparam int POS_W        = 10;
	localparam int PIX_W        = 3 * CHAN_W;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// floor(4p/25) = (p * Q4_MUL) >> Q4_SH for every 16-bit p
	localparam logic [20:0] Q4_MUL = 21'd1342180;
	localparam int          Q4_SH  = 23;
	localparam int          Q4_W   = 14;
	// floor(3p/10) = (p * Q3_MUL) >> Q3_SH for every 16-bit p
	localparam logic [20:0] Q3_MUL = 21'd1258293;
	localparam int          Q3_SH  = 22;
	localparam int          Q3_W   = 15;
	localparam int          PROD_W = 37;

	// Channel order inside a pixel word: index 2 red, 1 green, 0 blue
	typedef logic [2:0][CHAN_W-1:0] pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [POS_W-1:0]  out_row;
		logic [POS_W-1:0]  out_col;
		logic              run_last;
		logic              frame_last;
	} res_out_t;

	// Per-request position flags worked out at acceptance
	typedef struct packed {
		pix_t             cur;
		logic             first;
		logic             second;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             col_ok;
		logic             frame_last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col_a;
		logic [POS_W-1:0] col_b;
	} loc_t;

	// One pending result: center, four diagonals (already masked) and tags
	typedef struct packed {
		pix_t             ctr;
		pix_t [3:0]       dia;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             run_last;
		logic             frame_last;
	} res_t;

	function automatic logic [Q4_W-1:0] scale4(input logic [CHAN_W-1:0] p);
		logic [PROD_W-1:0] m;
		m = PROD_W'(p) * PROD_W'(Q4_MUL);
		return m[Q4_SH +: Q4_W];
	endfunction

	function automatic logic [Q3_W-1:0] scale3(input logic [CHAN_W-1:0] p);
		logic [PROD_W-1:0] m;
		m = PROD_W'(p) * PROD_W'(Q3_MUL);
		return m[Q3_SH +: Q3_W];
	endfunction

endpackage

// ===== hw/rtl/dwg_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dwg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/dwg_window.sv =====
// Line store read-modify-write, 3x3 window and two-entry result buffer.
// Depends on dwg_pkg and dwg_ram.
module dwg_window #(
	parameter int MAX_SIDE = dwg_pkg::DEF_MAX_SIDE,
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          take,
	input  logic [AW-1:0] addr,
	input  dwg_pkg::loc_t info,
	output logic          busy,
	output logic          req_valid,
	output dwg_pkg::res_t req,
	input  logic          req_ready
);
	import dwg_pkg::*;

	localparam int LW = 2 * PIX_W;

	logic          valid_s1;
	loc_t          info_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	logic [LW-1:0] fwd_data_s1;

	logic [1:0]    pend_s2;
	res_t [1:0]    res_s2;

	pix_t [8:0]    w_q;
	pix_t [8:0]    nw;

	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] line_rd;
	logic          we;
	logic [LW-1:0] wdata;
	pix_t          older;
	pix_t          newer;
	logic          s2_free;
	logic          s1_adv;
	logic          emit;
	logic [1:0]    emit_mask;
	res_t          ra;
	res_t          rb;

	// Line stores: entry holds {older row, newer row}
	dwg_ram #(.WIDTH(LW), .DEPTH(MAX_SIDE)) u_line (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (take),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Forward a write that lands in the same cycle as the read of the same entry
	assign line_rd = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign older   = line_rd[LW-1:PIX_W];
	assign newer   = line_rd[PIX_W-1:0];
	assign we      = s1_adv;
	assign wdata   = {newer, info_s1.cur};

	// Handshake between s1 and the result buffer
	assign s2_free   = (pend_s2 == 2'b00) || (req_ready && pend_s2 != 2'b11);
	assign s1_adv    = valid_s1 && s2_free;
	assign busy      = valid_s1 && !s2_free;
	assign req_valid = pend_s2 != 2'b00;
	assign emit      = req_valid && req_ready;
	assign emit_mask = pend_s2[0] ? 2'b01 : 2'b10;
	assign req       = pend_s2[0] ? res_s2[0] : res_s2[1];

	// Window after shifting in the new column
	always_comb begin
		nw[0] = w_q[1];
		nw[1] = w_q[2];
		nw[2] = older;
		nw[3] = w_q[4];
		nw[4] = w_q[5];
		nw[5] = newer;
		nw[6] = w_q[7];
		nw[7] = w_q[8];
		nw[8] = info_s1.cur;
	end

	// Result in the interior column, and the one at the right edge
	always_comb begin
		ra.ctr        = nw[4];
		ra.dia[0]     = (info_s1.top_ok && info_s1.left_ok) ? nw[0] : '0;
		ra.dia[1]     = info_s1.top_ok ? nw[2] : '0;
		ra.dia[2]     = (info_s1.bot_ok && info_s1.left_ok) ? nw[6] : '0;
		ra.dia[3]     = info_s1.bot_ok ? nw[8] : '0;
		ra.row        = info_s1.row;
		ra.col        = info_s1.col_a;
		ra.run_last   = !info_s1.second;
		ra.frame_last = 1'b0;

		rb.ctr        = nw[5];
		rb.dia[0]     = (info_s1.top_ok && info_s1.col_ok) ? nw[1] : '0;
		rb.dia[1]     = '0;
		rb.dia[2]     = (info_s1.bot_ok && info_s1.col_ok) ? nw[7] : '0;
		rb.dia[3]     = '0;
		rb.row        = info_s1.row;
		rb.col        = info_s1.col_b;
		rb.run_last   = 1'b1;
		rb.frame_last = info_s1.frame_last;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s2  <= 2'b00;
			w_q      <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (clear) begin
				w_q <= '0;
			end else if (s1_adv) begin
				w_q <= nw;
			end
			if (s1_adv) begin
				pend_s2 <= {info_s1.second, info_s1.first};
			end else if (emit) begin
				pend_s2 <= pend_s2 & ~emit_mask;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (take) begin
			info_s1     <= info;
			addr_s1     <= addr;
			fwd_s1      <= we && (addr_s1 == addr);
			fwd_data_s1 <= wdata;
		end
		if (s1_adv) begin
			res_s2[0] <= ra;
			res_s2[1] <= rb;
		end
	end

	// A pair always starts with a result that does not close the run
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s2 == 2'b11 |-> !res_s2[0].run_last)
		else $error("first of a result pair marked as run end");

	// A full buffer must hold back the stage in front of it
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pend_s2 == 2'b11 |-> busy && !take)
		else $error("s1 advanced into a full result buffer");

endmodule

// ===== hw/rtl/dwg_kernel.sv =====
// Weighted sum of one window result: constant scaling, then channel sums.
// Depends on dwg_pkg.
module dwg_kernel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  dwg_pkg::res_t     req,
	output logic              req_ready,
	output logic              out_valid,
	output dwg_pkg::res_out_t out,
	input  logic              out_stall
);
	import dwg_pkg::*;

	typedef struct packed {
		logic [2:0][Q3_W-1:0]      q3;
		logic [3:0][2:0][Q4_W-1:0] q4;
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          col;
		logic                      run_last;
		logic                      frame_last;
	} prod_t;

	logic                   valid_s3;
	prod_t                  prod_s3;
	prod_t                  prod;
	logic                   out_valid_q;
	res_out_t               out_q;
	res_out_t               sum;
	logic                   out_rdy;
	logic                   s3_rdy;
	logic [2:0][CHAN_W:0]   acc;

	assign out_rdy   = !out_valid_q || !out_stall;
	assign s3_rdy    = !valid_s3 || out_rdy;
	assign req_ready = s3_rdy;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	// Scale center and diagonals by their constant weights
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod.q3[c] = scale3(req.ctr[c]);
			for (int n = 0; n < 4; n++) begin
				prod.q4[n][c] = scale4(req.dia[n][c]);
			end
		end
		prod.row        = req.row;
		prod.col        = req.col;
		prod.run_last   = req.run_last;
		prod.frame_last = req.frame_last;
	end

	// Add the five terms of each channel; the total stays within 16 bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = (CHAN_W + 1)'(prod_s3.q3[c]) + (CHAN_W + 1)'(prod_s3.q4[0][c])
				+ (CHAN_W + 1)'(prod_s3.q4[1][c]) + (CHAN_W + 1)'(prod_s3.q4[2][c])
				+ (CHAN_W + 1)'(prod_s3.q4[3][c]);
		end
		sum.out_red    = acc[2][CHAN_W-1:0];
		sum.out_green  = acc[1][CHAN_W-1:0];
		sum.out_blue   = acc[0][CHAN_W-1:0];
		sum.out_row    = prod_s3.row;
		sum.out_col    = prod_s3.col;
		sum.run_last   = prod_s3.run_last;
		sum.frame_last = prod_s3.frame_last;
	end

	// Stage and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_rdy) begin
				valid_s3 <= req_valid;
			end
			if (out_rdy) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (s3_rdy && req_valid) begin
			prod_s3 <= prod;
		end
		if (out_rdy && valid_s3) begin
			out_q <= sum;
		end
	end

	// The frame's last pixel always closes its run
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_last |-> out_q.run_last)
		else $error("frame end without run end");

endmodule

// ===== hw/rtl/diagonal_weighted_glow_filter.sv =====
// Top level: image size register, raster position counters, window and kernel.
// Depends on dwg_pkg, dwg_window (with dwg_ram) and dwg_kernel.
// A result leaves s1 and passes the result buffer, s3 and the output register.
// Throughput: one pixel per clock while pix_stall is low, set by the line store
// read-modify-write (one 96-bit RAM, one read and one write port, write forwarding).
// From the second row on, a row's last pixel yields two results and holds back the
// next pixel while both wait, as at most one result leaves per clock. Reset clears
// control state and the window and loads size 1024; line stores are not initialized.
module diagonal_weighted_glow_filter #(
	parameter int MAX_SIDE = dwg_pkg::DEF_MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  dwg_pkg::pix_in_t                pix,
	output logic                            res_valid,
	input  logic                            res_stall,
	output dwg_pkg::res_out_t               res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dwg_pkg::SIZE_W-1:0]      cfg_data
);
	import dwg_pkg::*;

	localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DIM_W = $clog2(MAX_SIDE + 1);

	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0]  row_q;
	logic [AW-1:0]     col_q;

	logic              cfg_wr;
	logic              take;
	logic              busy;
	int unsigned       size_ext;
	logic [DIM_W-1:0]  dim;
	logic [DIM_W-1:0]  col_ext;
	logic [DIM_W-1:0]  col_nx;
	logic [DIM_W-1:0]  row_m1;
	logic [DIM_W-1:0]  col_m1;
	logic [DIM_W-1:0]  dim_m1;
	logic              row_end;
	loc_t              info;
	res_t              req;
	logic              req_valid;
	logic              req_ready;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign pix_stall = busy;
	assign take      = pix_valid && !busy;

	// Effective side length: zero acts as one, oversize as the maximum
	always_comb begin
		size_ext = 32'(size_q);
		if (size_ext == 0) begin
			dim = DIM_W'(1);
		end else if (size_ext > MAX_SIDE) begin
			dim = DIM_W'(MAX_SIDE);
		end else begin
			dim = DIM_W'(size_ext);
		end
	end

	// Position flags for the pixel being accepted
	always_comb begin
		col_ext = DIM_W'(col_q);
		col_nx  = col_ext + DIM_W'(1);
		row_m1  = row_q - DIM_W'(1);
		col_m1  = col_ext - DIM_W'(1);
		dim_m1  = dim - DIM_W'(1);
		row_end = col_nx >= dim;

		info.bot_ok     = row_q < dim;
		info.top_ok     = row_q >= DIM_W'(2);
		info.left_ok    = col_ext >= DIM_W'(2);
		info.col_ok     = col_ext != '0;
		info.first      = (row_q != '0) && (col_ext != '0);
		info.second     = (row_q != '0) && (col_nx == dim);
		info.frame_last = row_q == dim;
		info.row        = POS_W'(row_m1);
		info.col_a      = POS_W'(col_m1);
		info.col_b      = POS_W'(dim_m1);
		info.cur        = info.bot_ok ? {pix.in_red, pix.in_green, pix.in_blue} : '0;
	end

	// Size register and raster position; a size write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr) begin
			size_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (take) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_q >= dim) ? '0 : row_q + DIM_W'(1);
			end else begin
				col_q <= AW'(col_nx);
			end
		end
	end

	dwg_window #(.MAX_SIDE(MAX_SIDE)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_wr),
		.take      (take),
		.addr      (col_q),
		.info      (info),
		.busy      (busy),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	dwg_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.out_valid (res_valid),
		.out       (res),
		.out_stall (res_stall)
	);

	// The column always stays inside the current image width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		DIM_W'(col_q) < dim)
		else $error("column position beyond image width");

	// The row runs up to the filler row and no further
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= dim)
		else $error("row position beyond filler row");

endmodule
